FILE: rtl/sjgl_pkg.sv
// sjgl_pkg: types, constants and the lead-byte row function shared by the
// Shift-JIS glyph layout block. No dependencies.
`default_nettype none

package sjgl_pkg;

   localparam logic [7:0]  HALF_LOW     = 8'h20;   // first printable half-width byte
   localparam logic [7:0]  ASCII_END    = 8'h80;
   localparam logic [7:0]  KANA_LOW     = 8'ha0;
   localparam logic [7:0]  KANA_END     = 8'he0;
   localparam logic [7:0]  KANA_OFFSET  = 8'h40;
   localparam logic [7:0]  LEAD_LOW     = 8'h81;
   localparam logic [7:0]  LEAD_HIGH    = 8'he0;
   localparam logic [7:0]  LEAD_LAST    = 8'hfd;   // half-width lead byte
   localparam logic [7:0]  TRAIL_BASE   = 8'h40;
   localparam logic [7:0]  LEAD_MASK    = 8'h3f;
   localparam logic [14:0] HALF_COUNT   = 15'(16 * 10);
   localparam logic [14:0] ROW_GLYPHS   = 15'(2 * 192);

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        string_start;
      logic [8:0]  start_x;
      logic [8:0]  row_y;
      logic [23:0] text_colour;
   } req_item_type;

   typedef struct packed {
      logic [14:0] glyph_index;
      logic [8:0]  glyph_x;
      logic [8:0]  glyph_y;
      logic [23:0] glyph_colour;
      logic        last_glyph;
   } glyph_type;

   typedef struct packed {
      logic [1:0] count;
      glyph_type  first;
      glyph_type  second;
   } glyph_pair_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] row;
   } lead_row_type;

   function automatic logic is_lead(input logic [7:0] c);
      return (c >= LEAD_LOW && c < KANA_LOW) || (c >= LEAD_HIGH && c <= LEAD_LAST);
   endfunction

   // lead byte (low six bits) to font row, gaps are unmapped
   function automatic lead_row_type lead_row(input logic [5:0] idx);
      lead_row_type r;
      r.hit = 1'b0;
      r.row = '0;
      if (idx >= 6'd1 && idx <= 6'd4) begin
         r.hit = 1'b1;
         r.row = idx - 6'd1;
      end else if (idx >= 6'd7 && idx <= 6'd42) begin
         r.hit = 1'b1;
         r.row = idx - 6'd3;
      end else if (idx >= 6'd45 && idx <= 6'd46) begin
         r.hit = 1'b1;
         r.row = idx - 6'd5;
      end else if (idx >= 6'd56 && idx <= 6'd61) begin
         r.hit = 1'b1;
         r.row = idx - 6'd14;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sjgl_layout.sv
// sjgl_layout: string state (cursor, line, colour, held lead byte) and the
// per-byte glyph decode. Depends on sjgl_pkg.
`default_nettype none

module sjgl_layout #(
   parameter int SCREEN_WIDTH = 480,
   parameter int GLYPH_WIDTH  = 6
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        fire,
   input  wire sjgl_pkg::req_item_type item,
   output sjgl_pkg::glyph_pair_type   pair
);
   import sjgl_pkg::*;

   // cursor holds the widest start or edge plus one full-width advance
   localparam int XMAX = ((SCREEN_WIDTH > 512) ? SCREEN_WIDTH : 512) + 2 * GLYPH_WIDTH;
   localparam int XW   = $clog2(XMAX + 1);
   localparam logic [XW-1:0] LIMIT = XW'(SCREEN_WIDTH - GLYPH_WIDTH);
   localparam logic [XW-1:0] GW    = XW'(GLYPH_WIDTH);
   localparam logic [XW-1:0] GW2   = XW'(2 * GLYPH_WIDTH);

   logic [7:0]    pend_ff, pend_in;
   logic [XW-1:0] cursor_ff, cursor_in;
   logic [8:0]    y_ff, y_in;
   logic [23:0]   colour_ff, colour_in;
   logic          done_ff, done_in;

   logic [XW-1:0] base_x, x0, x1, adv;
   logic [7:0]    base_pend, c, off;
   logic          base_done;
   lead_row_type  lr;
   logic [14:0]   row_base, idx0, idx1;
   logic          g0_ok, g1_ok, full_ok;

   always_comb begin
      c         = item.text_byte;
      base_x    = item.string_start ? XW'(item.start_x) : cursor_ff;
      base_pend = item.string_start ? 8'h00 : pend_ff;
      base_done = item.string_start ? 1'b0 : done_ff;
      y_in      = item.string_start ? item.row_y : y_ff;
      colour_in = item.string_start ? item.text_colour : colour_ff;
      pend_in   = base_pend;
      done_in   = base_done;
      adv       = '0;
      g0_ok     = 1'b0;
      g1_ok     = 1'b0;
      idx0      = '0;
      lr        = lead_row(base_pend[5:0] & LEAD_MASK[5:0]);
      off       = c - TRAIL_BASE;
      full_ok   = (c >= TRAIL_BASE) && lr.hit;
      row_base  = HALF_COUNT + 15'(lr.row) * ROW_GLYPHS;
      if (!base_done) begin
         if (c == 8'h00) begin
            pend_in = 8'h00;
            done_in = 1'b1;
         end else begin
            if (base_pend != 8'h00) begin
               pend_in = 8'h00;
               g0_ok   = full_ok;
               if (base_pend == LEAD_LAST) begin
                  idx0 = row_base + 15'(off);
                  adv  = GW;
               end else begin
                  idx0  = row_base + 15'({off, 1'b0});
                  g1_ok = full_ok;
                  adv   = GW2;
               end
            end else if (is_lead(c)) begin
               pend_in = c;
            end else begin
               adv = GW;
               if (c >= HALF_LOW && c < ASCII_END) begin
                  g0_ok = 1'b1;
                  idx0  = 15'(c - HALF_LOW);
               end else if (c >= KANA_LOW && c < KANA_END) begin
                  g0_ok = 1'b1;
                  idx0  = 15'(c - KANA_OFFSET);
               end
            end
         end
      end
      cursor_in = base_x + adv;
      if (!base_done && c != 8'h00 && cursor_in > LIMIT) begin
         done_in = 1'b1;
         pend_in = 8'h00;
      end
      idx1 = idx0 + 15'd1;
      x0   = base_x;
      x1   = base_x + GW;
      // glyphs past the right edge are dropped
      g0_ok = g0_ok && (x0 <= LIMIT);
      g1_ok = g1_ok && (x1 <= LIMIT);

      pair.count               = {1'b0, g0_ok} + {1'b0, g1_ok};
      pair.first.glyph_index   = idx0;
      pair.first.glyph_x       = x0[8:0];
      pair.first.glyph_y       = y_in;
      pair.first.glyph_colour  = colour_in;
      pair.first.last_glyph    = !g1_ok;
      pair.second.glyph_index  = idx1;
      pair.second.glyph_x      = x1[8:0];
      pair.second.glyph_y      = y_in;
      pair.second.glyph_colour = colour_in;
      pair.second.last_glyph   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 8'h00;
         cursor_ff <= '0;
         y_ff      <= '0;
         colour_ff <= '0;
         done_ff   <= 1'b1;
      end else if (fire) begin
         pend_ff   <= pend_in;
         cursor_ff <= (base_done || c == 8'h00) ? base_x : cursor_in;
         y_ff      <= y_in;
         colour_ff <= colour_in;
         done_ff   <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sjgl_out_queue.sv
// sjgl_out_queue: two-slot result queue, loaded with up to two glyphs at once
// and drained one transfer at a time. Depends on sjgl_pkg.
`default_nettype none

module sjgl_out_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          load,
   input  wire sjgl_pkg::glyph_pair_type pair,
   output logic                         can_load,
   output logic                         out_valid,
   input  wire                          out_ready,
   output sjgl_pkg::glyph_type          out_glyph
);
   import sjgl_pkg::*;

   glyph_type  slot0_ff, slot1_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_glyph = slot0_ff;
   assign pop       = out_valid && out_ready;
   // a pair may land as the last queued glyph leaves
   assign can_load  = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load) begin
         count_ff <= pair.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot0_ff <= pair.first;
         slot1_ff <= pair.second;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/shift_jis_glyph_layout.sv
// shift_jis_glyph_layout: top level, input register feeding the layout decode
// and the result queue. Depends on sjgl_pkg, sjgl_layout, sjgl_out_queue.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    text byte, string start, x, row, colour
//   rsp      out  valid / ready    glyph index, x, y, colour, last glyph
//
// a byte is held in the input register, then is decoded in one pass into the
// two-slot result queue, whose single output port sets the rate: a byte of
// zero or one glyph does not delay the next; a full-width pair drains first.
// synchronous reset clears the string state (no string active) and empties
// both stages. a stalled rsp holds the queue and backs up into req_ready.
`default_nettype none

module shift_jis_glyph_layout #(
   parameter int SCREEN_WIDTH = 480,
   parameter int GLYPH_WIDTH  = 6
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [7:0]   req_text_byte,
   input  wire          req_string_start,
   input  wire  [8:0]   req_start_x,
   input  wire  [8:0]   req_row_y,
   input  wire  [23:0]  req_text_colour,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [14:0]  rsp_glyph_index,
   output logic [8:0]   rsp_glyph_x,
   output logic [8:0]   rsp_glyph_y,
   output logic [23:0]  rsp_glyph_colour,
   output logic         rsp_last_glyph
);
   import sjgl_pkg::*;

   req_item_type   item_ff;
   logic           item_valid_ff;
   logic           can_load, advance;
   glyph_pair_type pair;
   glyph_type      glyph;

   assign advance   = item_valid_ff && can_load;
   assign req_ready = !item_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.text_byte    <= req_text_byte;
         item_ff.string_start <= req_string_start;
         item_ff.start_x      <= req_start_x;
         item_ff.row_y        <= req_row_y;
         item_ff.text_colour  <= req_text_colour;
      end
   end

   sjgl_layout #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .GLYPH_WIDTH  (GLYPH_WIDTH)
   ) u_layout (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .pair  (pair)
   );

   sjgl_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .pair      (pair),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_glyph (glyph)
   );

   assign rsp_glyph_index  = glyph.glyph_index;
   assign rsp_glyph_x      = glyph.glyph_x;
   assign rsp_glyph_y      = glyph.glyph_y;
   assign rsp_glyph_colour = glyph.glyph_colour;
   assign rsp_last_glyph   = glyph.last_glyph;

endmodule

`default_nettype wire
